// ----- sv/rrwe_pkg.sv -----
// Shared types, sizes and helpers for the refresh rate window estimator.
package rrwe_pkg;

    localparam int WINDOW_DEPTH   = 256;
    localparam int RATE_FRAC_BITS = 16;

    localparam int IDX_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int ISUM_W = 16 + CNT_W;
    localparam int ESUM_W = 32 + CNT_W;
    localparam int PROD_W = ISUM_W + 32;
    localparam int DVD_W  = PROD_W + RATE_FRAC_BITS;
    localparam int BIT_W  = $clog2(DVD_W + 1);
    localparam int ENTRY_W = 96;

    localparam logic [7:0] REG_TICK_FREQUENCY  = 8'd0;
    localparam logic [7:0] REG_RETENTION_TICKS = 8'd1;

    localparam logic [31:0] TICK_FREQUENCY_RST  = 32'd10000000;
    localparam logic [47:0] RETENTION_TICKS_RST = 48'd10000000;

    typedef struct packed {
        logic        kind;
        logic [47:0] end_time;
        logic [31:0] elapsed_time;
        logic [15:0] interval_count;
    } in_t;

    typedef struct packed {
        logic [8:0]  sample_count;
        logic [23:0] interval_total;
        logic [31:0] min_wait;
        logic [31:0] max_wait;
        logic [39:0] refresh_rate_q16;
        logic [39:0] raw_rate_q16;
        logic        dropped_full;
    } out_t;

    typedef struct packed {
        logic [47:0] end_time;
        logic [31:0] elapsed_time;
        logic [15:0] interval_count;
    } entry_t;

    // Wrap a ring position that may run up to twice the depth.
    function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W+CNT_W-1:0] a);
        logic [IDX_W+CNT_W-1:0] b;
        b = (a >= (IDX_W+CNT_W)'(WINDOW_DEPTH)) ? a - (IDX_W+CNT_W)'(WINDOW_DEPTH) : a;
        return b[IDX_W-1:0];
    endfunction

endpackage

// ----- sv/refresh_rate_window_estimator.sv -----
// Refresh rate window estimator: ring store, eviction walk, min/max walk, rate divider.
//
// One result beat per input beat. A valid sample passes from acceptance to the result register
// through the drop of a full ring's oldest entry, the store, the eviction of aged-out entries,
// the min/max walk and the divider. Each entry dropped (full ring or aged out) takes a read
// state and a check state on the single memory read port. The walk issues one read per cycle
// over the N entries left in the window, then drains the last read. The serial restoring
// divider, over DVD = 73 bits, runs once per rate with a load step and a finish step. An
// invalid sample skips the drop, store and eviction; a clear, or any item that leaves the
// window empty or meets a zero frequency, also skips the walk and the divider. A result that
// waits for out_ready stalls the next item in its done state until it is taken. The samples
// sit in a 256 x 96 synchronous memory that needs no clearing pass; only entries inside the
// window are ever read. Configuration writes are taken at any time (cfg_ready is always high)
// and must only be made while idle.
module refresh_rate_window_estimator (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  rrwe_pkg::in_t   in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output rrwe_pkg::out_t  out_data,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [7:0]      cfg_index,
    input  logic [47:0]     cfg_data
);
    import rrwe_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DROP_RD = 4'd1;
    localparam logic [3:0] S_DROP    = 4'd2;
    localparam logic [3:0] S_STORE   = 4'd3;
    localparam logic [3:0] S_EV_RD   = 4'd4;
    localparam logic [3:0] S_EV_CHK  = 4'd5;
    localparam logic [3:0] S_WALK0   = 4'd6;
    localparam logic [3:0] S_WALK    = 4'd7;
    localparam logic [3:0] S_MUL     = 4'd8;
    localparam logic [3:0] S_DIV     = 4'd9;
    localparam logic [3:0] S_DONE    = 4'd10;

    logic [3:0]        state_reg, state_next;
    logic [31:0]       freq_reg;
    logic [47:0]       ret_reg;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ISUM_W-1:0] isum_reg, isum_next;
    logic [ESUM_W-1:0] esum_reg, esum_next;
    in_t               item_reg, item_next;
    logic              drop_reg, drop_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              rdv_reg, rdv_next;
    logic [31:0]       mn_reg, mn_next, mx_reg, mx_next;
    logic              sel_reg, sel_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [ESUM_W-1:0] rem_reg, rem_next;
    logic [BIT_W-1:0]  bit_reg, bit_next;
    out_t              res_reg, res_next;
    logic              out_valid_reg;
    out_t              out_data_reg;

    // sample memory
    entry_t            mem [WINDOW_DEPTH];
    entry_t            mem_rdata;
    logic              mem_rd_en, mem_we;
    logic [IDX_W-1:0]  mem_rd_addr, mem_wr_addr;
    entry_t            mem_wdata;

    logic [47:0]       age;
    logic [ESUM_W:0]   rem_shift;
    logic [39:0]       q_sat;
    logic              valid_sample;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign valid_sample = (in_data.end_time != '0) && (in_data.elapsed_time != '0)
                          && (in_data.interval_count != '0);
    assign age = (item_reg.end_time >= mem_rdata.end_time)
                 ? item_reg.end_time - mem_rdata.end_time : 48'd0;
    assign rem_shift = {rem_reg, dvd_reg[DVD_W-1]};
    assign q_sat = (dvd_reg[DVD_W-1:40] != '0) ? {40{1'b1}} : dvd_reg[39:0];

    // Memory port selection
    always_comb
    begin
        mem_rd_en   = 1'b0;
        mem_rd_addr = head_reg;
        mem_we      = (state_reg == S_STORE);
        mem_wr_addr = wrap_idx({{CNT_W{1'b0}}, head_reg} + {{IDX_W{1'b0}}, count_reg});
        mem_wdata   = '{end_time: item_reg.end_time, elapsed_time: item_reg.elapsed_time,
                        interval_count: item_reg.interval_count};
        case (state_reg)
            S_DROP_RD: mem_rd_en = 1'b1;
            S_EV_RD:   mem_rd_en = (count_reg != '0);
            S_WALK:
            begin
                mem_rd_en   = (idx_reg < count_reg);
                mem_rd_addr = wrap_idx({{CNT_W{1'b0}}, head_reg} + {{IDX_W{1'b0}}, idx_reg});
            end
            default: mem_rd_en = 1'b0;
        endcase
    end

    // Hold samples; registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wr_addr] <= mem_wdata;
        end
        if (mem_rd_en)
        begin
            mem_rdata <= mem[mem_rd_addr];
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        isum_next  = isum_reg;
        esum_next  = esum_reg;
        item_next  = item_reg;
        drop_next  = drop_reg;
        idx_next   = idx_reg;
        rdv_next   = 1'b0;
        mn_next    = mn_reg;
        mx_next    = mx_reg;
        sel_next   = sel_reg;
        prod_next  = prod_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        bit_next   = bit_reg;
        res_next   = res_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_data;
                    drop_next  = 1'b0;
                    state_next = S_WALK0;
                    if (in_data.kind)
                    begin
                        head_next  = '0;
                        count_next = '0;
                        isum_next  = '0;
                        esum_next  = '0;
                    end
                    else if (valid_sample)
                    begin
                        state_next = (count_reg == CNT_W'(WINDOW_DEPTH)) ? S_DROP_RD : S_STORE;
                    end
                end
            end
            S_DROP_RD: state_next = S_DROP;
            S_DROP:
            begin
                // drop oldest entry of a full ring
                isum_next  = isum_reg - ISUM_W'(mem_rdata.interval_count);
                esum_next  = esum_reg - ESUM_W'(mem_rdata.elapsed_time);
                head_next  = wrap_idx({{CNT_W{1'b0}}, head_reg} + (IDX_W+CNT_W)'(1));
                count_next = count_reg - CNT_W'(1);
                drop_next  = 1'b1;
                state_next = S_STORE;
            end
            S_STORE:
            begin
                count_next = count_reg + CNT_W'(1);
                isum_next  = isum_reg + ISUM_W'(item_reg.interval_count);
                esum_next  = esum_reg + ESUM_W'(item_reg.elapsed_time);
                state_next = S_EV_RD;
                if (ret_reg == '0)
                begin
                    head_next  = '0;
                    count_next = '0;
                    isum_next  = '0;
                    esum_next  = '0;
                    state_next = S_WALK0;
                end
            end
            S_EV_RD: state_next = (count_reg == '0) ? S_WALK0 : S_EV_CHK;
            S_EV_CHK:
            begin
                // evict aged-out oldest entry, else stop
                if (age > ret_reg)
                begin
                    isum_next  = isum_reg - ISUM_W'(mem_rdata.interval_count);
                    esum_next  = esum_reg - ESUM_W'(mem_rdata.elapsed_time);
                    head_next  = wrap_idx({{CNT_W{1'b0}}, head_reg} + (IDX_W+CNT_W)'(1));
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_EV_RD;
                end
                else
                begin
                    state_next = S_WALK0;
                end
            end
            S_WALK0:
            begin
                res_next = '0;
                res_next.dropped_full = drop_reg && (freq_reg != '0);
                idx_next = '0;
                mn_next  = '1;
                mx_next  = '0;
                if (freq_reg == '0 || count_reg == '0 || esum_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                // issue one read per cycle, fold the returning beat
                if (idx_reg < count_reg)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                    rdv_next = 1'b1;
                end
                if (rdv_reg)
                begin
                    if (mem_rdata.elapsed_time < mn_reg)
                    begin
                        mn_next = mem_rdata.elapsed_time;
                    end
                    if (mem_rdata.elapsed_time > mx_reg)
                    begin
                        mx_next = mem_rdata.elapsed_time;
                    end
                    if (idx_reg == count_reg)
                    begin
                        sel_next   = 1'b0;
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                res_next.sample_count   = 9'(count_reg);
                res_next.interval_total = (isum_reg > ISUM_W'(24'hFFFFFF))
                                          ? 24'hFFFFFF : isum_reg[23:0];
                res_next.min_wait       = mn_reg;
                res_next.max_wait       = mx_reg;
                if (sel_reg)
                begin
                    prod_next = PROD_W'({{(ISUM_W-CNT_W){1'b0}}, count_reg} * freq_reg);
                end
                else
                begin
                    prod_next = PROD_W'(isum_reg * freq_reg);
                end
                dvd_next   = '0;
                rem_next   = '0;
                bit_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (bit_reg == '0 && rem_reg == '0 && dvd_reg == '0)
                begin
                    dvd_next = {prod_reg, {RATE_FRAC_BITS{1'b0}}};
                    bit_next = BIT_W'(1);
                end
                else if (bit_reg <= BIT_W'(DVD_W))
                begin
                    // one restoring step: shift in a dividend bit, subtract if it fits
                    if (rem_shift >= {1'b0, esum_reg})
                    begin
                        rem_next = ESUM_W'(rem_shift - {1'b0, esum_reg});
                        dvd_next = {dvd_reg[DVD_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rem_shift[ESUM_W-1:0];
                        dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
                    end
                    bit_next = bit_reg + BIT_W'(1);
                end
                else
                begin
                    if (sel_reg)
                    begin
                        res_next.raw_rate_q16 = q_sat;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        res_next.refresh_rate_q16 = q_sat;
                        sel_next   = 1'b1;
                        state_next = S_MUL;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Advance control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            isum_reg      <= '0;
            esum_reg      <= '0;
            rdv_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            freq_reg      <= TICK_FREQUENCY_RST;
            ret_reg       <= RETENTION_TICKS_RST;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            isum_reg  <= isum_next;
            esum_reg  <= esum_next;
            rdv_reg   <= rdv_next;
            if (state_reg == S_DONE && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_index == REG_TICK_FREQUENCY)
            begin
                freq_reg <= cfg_data[31:0];
            end
            if (cfg_valid && cfg_index == REG_RETENTION_TICKS)
            begin
                ret_reg <= cfg_data;
            end
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        drop_reg <= drop_next;
        idx_reg  <= idx_next;
        mn_reg   <= mn_next;
        mx_reg   <= mx_next;
        sel_reg  <= sel_next;
        prod_reg <= prod_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        bit_reg  <= bit_next;
        res_reg  <= res_next;
        if (state_reg == S_DONE && (!out_valid_reg || out_ready))
        begin
            out_data_reg <= res_reg;
        end
    end

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(WINDOW_DEPTH))
        else $error("window count above depth");
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_data.kind) |=> (count_reg == '0))
        else $error("clear left entries");
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.min_wait <= out_data.max_wait
                       || out_data.sample_count == '0))
        else $error("min above max");
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.sample_count == '0) |->
        (out_data.interval_total == '0 && out_data.raw_rate_q16 == '0))
        else $error("empty window with nonzero result");
endmodule
